// ===== hdl/imuho_pkg.sv =====
// package: widths, defaults, quadrant codes and sine table builder for the odometry block
`timescale 1ns / 1ps
`default_nettype none

package imuho_pkg;

   // default parameter values
   localparam int IMUHO_SINE_TABLE_DEPTH   = 256;
   localparam int IMUHO_TRIG_FRACTION_BITS = 16;

   // field widths
   localparam int WHEEL_W   = 32;
   localparam int HEADING_W = 16;
   localparam int POS_W     = 40;
   localparam int DELTA_W   = WHEEL_W + 2;

   // stream data widths
   localparam int REQ_DATA_W = 2 * WHEEL_W + HEADING_W;
   localparam int RSP_DATA_W = 2 * POS_W;

   // pi/2 in q30
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // quadrant of the heading
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // sine of a q30 angle by a taylor series up to the x^25 term
   function automatic longint sine_q30(input longint x);
      longint x2;
      longint mag;
      longint sum;
      longint t;
      x2  = (x * x) >>> 30;
      mag = x;
      sum = x;
      for (int k = 1; k <= 12; k++) begin
         t = (mag * x2) >>> 30;
         case (k)
            1:       mag = t / 6;
            2:       mag = t / 20;
            3:       mag = t / 42;
            4:       mag = t / 72;
            5:       mag = t / 110;
            6:       mag = t / 156;
            7:       mag = t / 210;
            8:       mag = t / 272;
            9:       mag = t / 342;
            10:      mag = t / 420;
            11:      mag = t / 506;
            default: mag = t / 600;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - mag;
         end else begin
            sum = sum + mag;
         end
      end
      return sum;
   endfunction

   // one table entry: sine rounded half up to frac bits, clamped to 1.0
   function automatic longint sine_entry(input longint x, input int frac);
      longint s;
      longint e;
      longint one;
      one = longint'(1) << frac;
      s   = sine_q30(x);
      if (s < 0) begin
         s = 0;
      end
      e = ((s << frac) + (longint'(1) << 29)) >>> 30;
      if (e > one) begin
         e = one;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/imu_heading_odometry.sv =====
// top level: wheel-delta and imu-heading dead reckoning, three register stages
//
//   port group | dir | payload (low bit up)
//   -----------+-----+-------------------------------------------------
//   req_*      | in  | left_distance[31:0], right_distance[31:0],
//              |     | heading_angle[15:0]
//   rsp_*      | out | pos_x[39:0], pos_y[39:0]
//
// one beat in and one beat out per cycle when neither side stalls; a result
// reaches the result port through the delta register, loaded at the edge that
// accepts its input beat, then the product register, then the position register
// each stage loads when it is empty or its contents move on, so a stalled
// result does not block inputs until all three stages are full
// reset clears the stage valids, the previous wheel positions and the position
// accumulators; the sine table is constant logic and needs no load

`timescale 1ns / 1ps
`default_nettype none

module imu_heading_odometry import imuho_pkg::*; #(
   parameter int SINE_TABLE_DEPTH   = IMUHO_SINE_TABLE_DEPTH,
   parameter int TRIG_FRACTION_BITS = IMUHO_TRIG_FRACTION_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // left_distance, right_distance, heading_angle
   // result stream
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata   // pos_x, pos_y
);

   localparam int TRIG_W = TRIG_FRACTION_BITS + 2;
   localparam int PROD_W = DELTA_W + TRIG_W;

   // stage control
   logic delta_valid_ff, delta_valid_in;
   logic prod_valid_ff,  prod_valid_in;
   logic rsp_valid_ff,   rsp_valid_in;
   logic out_free;
   logic prod_free;
   logic req_beat;

   // state and payload
   logic signed [WHEEL_W-1:0]   prev_left_ff,  prev_left_in;
   logic signed [WHEEL_W-1:0]   prev_right_ff, prev_right_in;
   logic signed [DELTA_W-1:0]   delta_ff,      delta_in;
   logic        [HEADING_W-1:0] heading_ff,    heading_in;
   logic signed [PROD_W-1:0]    prod_x_ff,     prod_x_in;
   logic signed [PROD_W-1:0]    prod_y_ff,     prod_y_in;
   logic signed [POS_W-1:0]     acc_x_ff,      acc_x_in;
   logic signed [POS_W-1:0]     acc_y_ff,      acc_y_in;

   logic signed [WHEEL_W-1:0]  left_dist;
   logic signed [WHEEL_W-1:0]  right_dist;
   logic signed [WHEEL_W:0]    diff_left;
   logic signed [WHEEL_W:0]    diff_right;
   logic signed [TRIG_W-1:0]   sin_val;
   logic signed [TRIG_W-1:0]   cos_val;
   logic signed [POS_W-1:0]    acc_x_next;
   logic signed [POS_W-1:0]    acc_y_next;

   // handshake and stage advance
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign prod_free  = !prod_valid_ff || out_free;
   assign req_tready = !delta_valid_ff || prod_free;
   assign req_beat   = req_tvalid && req_tready;

   assign delta_valid_in = req_tready ? req_tvalid : delta_valid_ff;
   assign prod_valid_in  = prod_free ? delta_valid_ff : prod_valid_ff;
   assign rsp_valid_in   = out_free ? prod_valid_ff : rsp_valid_ff;

   // unpack the input beat
   assign left_dist  = req_tdata[0 +: WHEEL_W];
   assign right_dist = req_tdata[WHEEL_W +: WHEEL_W];

   // exact wheel deltas against the previous sample, summed into the delta register
   assign diff_left  = {left_dist[WHEEL_W-1], left_dist} - {prev_left_ff[WHEEL_W-1], prev_left_ff};
   assign diff_right = {right_dist[WHEEL_W-1], right_dist}
                     - {prev_right_ff[WHEEL_W-1], prev_right_ff};

   always_comb begin
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      delta_in      = delta_ff;
      heading_in    = heading_ff;
      if (req_beat) begin
         prev_left_in  = left_dist;
         prev_right_in = right_dist;
         delta_in      = {diff_left[WHEEL_W], diff_left} + {diff_right[WHEEL_W], diff_right};
         heading_in    = req_tdata[2*WHEEL_W +: HEADING_W];
      end
   end

   // heading lookup
   imuho_trig #(
      .SINE_TABLE_DEPTH  (SINE_TABLE_DEPTH),
      .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
   ) u_trig (
      .heading(heading_ff),
      .sin_out(sin_val),
      .cos_out(cos_val)
   );

   // travel times cosine and sine
   always_comb begin
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      if (prod_free && delta_valid_ff) begin
         prod_x_in = delta_ff * cos_val;
         prod_y_in = delta_ff * sin_val;
      end
   end

   // saturating position update
   imuho_accum #(
      .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
   ) u_accum_x (
      .product (prod_x_ff),
      .acc_cur (acc_x_ff),
      .acc_next(acc_x_next)
   );

   imuho_accum #(
      .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
   ) u_accum_y (
      .product (prod_y_ff),
      .acc_cur (acc_y_ff),
      .acc_next(acc_y_next)
   );

   assign acc_x_in = (out_free && prod_valid_ff) ? acc_x_next : acc_x_ff;
   assign acc_y_in = (out_free && prod_valid_ff) ? acc_y_next : acc_y_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_valid_ff <= 1'b0;
         prod_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_left_ff   <= '0;
         prev_right_ff  <= '0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
      end else begin
         delta_valid_ff <= delta_valid_in;
         prod_valid_ff  <= prod_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         prev_left_ff   <= prev_left_in;
         prev_right_ff  <= prev_right_in;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      heading_ff <= heading_in;
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
   end

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {acc_y_ff, acc_x_ff};

endmodule

`default_nettype wire

// ===== hdl/imuho_trig.sv =====
// quarter-wave sine and cosine lookup of a heading given as a fraction of a turn
`timescale 1ns / 1ps
`default_nettype none

module imuho_trig import imuho_pkg::*; #(
   parameter int SINE_TABLE_DEPTH   = IMUHO_SINE_TABLE_DEPTH,
   parameter int TRIG_FRACTION_BITS = IMUHO_TRIG_FRACTION_BITS
) (
   input  wire logic        [HEADING_W-1:0]          heading,
   output      logic signed [TRIG_FRACTION_BITS+1:0] sin_out,
   output      logic signed [TRIG_FRACTION_BITS+1:0] cos_out
);

   localparam int ENTRY_W = TRIG_FRACTION_BITS + 1;
   localparam int TRIG_W  = TRIG_FRACTION_BITS + 2;
   localparam int PHASE_W = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int OFF_W   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SCALE_W = HEADING_W + PHASE_W + 1;

   // constant quarter-wave table, entry DEPTH is exactly 1.0
   logic [ENTRY_W-1:0] sine_tab [0:SINE_TABLE_DEPTH];

   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_tab
      localparam longint XQ30 =
         (HALF_PI_Q30 * i + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      assign sine_tab[i] = ENTRY_W'(sine_entry(XQ30, TRIG_FRACTION_BITS));
   end

   logic [SCALE_W-1:0] scaled;
   logic [PHASE_W-1:0] phase;
   quad_type           quad;
   logic [OFF_W-1:0]   off;
   logic [OFF_W-1:0]   comp;
   logic [TRIG_W-1:0]  near_val;
   logic [TRIG_W-1:0]  far_val;

   // phase index over four quarters
   assign scaled = SCALE_W'(heading) * SCALE_W'(4 * SINE_TABLE_DEPTH);
   assign phase  = scaled[HEADING_W +: PHASE_W];

   // split phase into quadrant and offset
   always_comb begin
      priority if (phase >= PHASE_W'(3 * SINE_TABLE_DEPTH)) begin
         quad = QUAD_3;
         off  = OFF_W'(phase - PHASE_W'(3 * SINE_TABLE_DEPTH));
      end else if (phase >= PHASE_W'(2 * SINE_TABLE_DEPTH)) begin
         quad = QUAD_2;
         off  = OFF_W'(phase - PHASE_W'(2 * SINE_TABLE_DEPTH));
      end else if (phase >= PHASE_W'(SINE_TABLE_DEPTH)) begin
         quad = QUAD_1;
         off  = OFF_W'(phase - PHASE_W'(SINE_TABLE_DEPTH));
      end else begin
         quad = QUAD_0;
         off  = OFF_W'(phase);
      end
   end

   assign comp     = OFF_W'(SINE_TABLE_DEPTH) - off;
   assign near_val = {1'b0, sine_tab[off]};
   assign far_val  = {1'b0, sine_tab[comp]};

   // quadrant symmetry
   always_comb begin
      unique case (quad)
         QUAD_0: begin
            sin_out = $signed(near_val);
            cos_out = $signed(far_val);
         end
         QUAD_1: begin
            sin_out = $signed(far_val);
            cos_out = -$signed(near_val);
         end
         QUAD_2: begin
            sin_out = -$signed(near_val);
            cos_out = -$signed(far_val);
         end
         QUAD_3: begin
            sin_out = -$signed(far_val);
            cos_out = $signed(near_val);
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/imuho_accum.sv =====
// rounding of a scaled product to q.7 and saturating add to a 40-bit position
`timescale 1ns / 1ps
`default_nettype none

module imuho_accum import imuho_pkg::*; #(
   parameter int TRIG_FRACTION_BITS = IMUHO_TRIG_FRACTION_BITS
) (
   input  wire logic signed [DELTA_W+TRIG_FRACTION_BITS+1:0] product,
   input  wire logic signed [POS_W-1:0]                      acc_cur,
   output      logic signed [POS_W-1:0]                      acc_next
);

   localparam int PROD_W = DELTA_W + TRIG_FRACTION_BITS + 2;
   localparam int SHIFT  = TRIG_FRACTION_BITS - 7;
   localparam int INC_W  = PROD_W - SHIFT;
   localparam int SUM_W  = INC_W + 1;

   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] shifted;
   logic signed [INC_W-1:0]  incr;
   logic signed [SUM_W-1:0]  sum;
   logic                     in_range;

   // round half up, floor shift
   assign rounded = product + PROD_W'(longint'(1) << (SHIFT - 1));
   assign shifted = rounded >>> SHIFT;
   assign incr    = shifted[INC_W-1:0];

   assign sum = SUM_W'(acc_cur) + SUM_W'(incr);

   // fits when all bits above the position sign match it
   assign in_range = (sum[SUM_W-1:POS_W-1] == '0) || (sum[SUM_W-1:POS_W-1] == '1);

   // clamp to the signed limits
   always_comb begin
      priority if (in_range) begin
         acc_next = sum[POS_W-1:0];
      end else if (sum[SUM_W-1]) begin
         acc_next = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         acc_next = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire
